FILE: hdl/sfct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfct_pkg: shared types and constants of the sparse flow counter table
// Table size, count widths, request modes, register indexes and the token
// that walks the cell chain.
// ----------------------------------------------------------------------------
package sfct_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic [1:0] {
    MODE_ACCUM = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_PRUNE = 2'd2,
    MODE_HEAVY = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PKT_THR  = 1'b0,
    CFG_BYTE_THR = 1'b1
  } cfg_reg_e;

  // Token handed from cell to cell; one per pass over the table.
  typedef struct packed {
    logic  active;
    logic  fill;      // insert pass: first free cell claims the entry
    mode_e mode;
    word_t key;
    word_t pinc;
    word_t binc;
    logic  hit;
    logic  any_free;
    logic  placed;
    word_t ptot;
    word_t btot;
    cnt_t  removed;
    cnt_t  heavy_p;
    cnt_t  heavy_b;
  } tok_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? '1 : s[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sfct_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfct interfaces: request, response and register write channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sfct_req_if import sfct_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  word_t       key_index;
  word_t       packet_increment;
  word_t       byte_increment;

  modport source (output valid, mode, key_index, packet_increment, byte_increment,
                  input ready);
  modport sink   (input valid, mode, key_index, packet_increment, byte_increment,
                  output ready);
endinterface

interface sfct_rsp_if import sfct_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     found;
  word_t    packet_total;
  word_t    byte_total;
  logic     dropped;
  out_cnt_t entry_count;
  out_cnt_t heavy_by_packets;
  out_cnt_t heavy_by_bytes;

  modport source (output valid, found, packet_total, byte_total, dropped, entry_count,
                         heavy_by_packets, heavy_by_bytes,
                  input ready);
  modport sink   (input valid, found, packet_total, byte_total, dropped, entry_count,
                        heavy_by_packets, heavy_by_bytes,
                  output ready);
endinterface

interface sfct_cfg_if import sfct_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sfct_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfct_cell: one table slot of the counter chain
// Holds one entry, acts on the passing token and hands it to the next cell.
// ----------------------------------------------------------------------------
module sfct_cell import sfct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  word_t pkt_thr_i,
  input  word_t byte_thr_i,
  input  tok_t  tok_i,
  output tok_t  tok_o
);

  logic  valid_q, valid_d;
  word_t key_q, key_d;
  word_t pkt_q, pkt_d;
  word_t byt_q, byt_d;
  logic  act_q;
  tok_t  tok_q, tok_d;
  logic  match;
  word_t sum_p, sum_b;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    key_d   = key_q;
    pkt_d   = pkt_q;
    byt_d   = byt_q;
    match   = valid_q && (key_q == tok_i.key);
    sum_p   = sat_add(pkt_q, tok_i.pinc);
    sum_b   = sat_add(byt_q, tok_i.binc);
    if (tok_i.active) begin
      if (tok_i.fill) begin
        // claim the entry in the lowest free slot
        if (!valid_q && !tok_i.placed) begin
          valid_d      = 1'b1;
          key_d        = tok_i.key;
          pkt_d        = tok_i.pinc;
          byt_d        = tok_i.binc;
          tok_d.placed = 1'b1;
        end
      end else begin
        case (tok_i.mode)
          MODE_ACCUM: begin
            if (match && !tok_i.hit) begin
              pkt_d      = sum_p;
              byt_d      = sum_b;
              tok_d.hit  = 1'b1;
              tok_d.ptot = sum_p;
              tok_d.btot = sum_b;
            end
            if (!valid_q) begin
              tok_d.any_free = 1'b1;
            end
          end
          MODE_QUERY: begin
            if (match && !tok_i.hit) begin
              tok_d.hit  = 1'b1;
              tok_d.ptot = pkt_q;
              tok_d.btot = byt_q;
            end
          end
          MODE_PRUNE: begin
            if (valid_q && (key_q >= tok_i.key)) begin
              valid_d       = 1'b0;
              tok_d.removed = tok_i.removed + cnt_t'(1);
            end
          end
          MODE_HEAVY: begin
            if (valid_q && (pkt_q >= pkt_thr_i)) begin
              tok_d.heavy_p = tok_i.heavy_p + cnt_t'(1);
            end
            if (valid_q && (byt_q >= byte_thr_i)) begin
              tok_d.heavy_b = tok_i.heavy_b + cnt_t'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      act_q   <= tok_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pkt_q <= pkt_d;
    byt_q <= byt_d;
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = act_q;
  end

endmodule
`default_nettype wire

FILE: hdl/sparse_flow_counter_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_flow_counter_table: associative table of packet and byte counters
// A row of CAPACITY slot cells; each request walks the row one cell a cycle.
// ----------------------------------------------------------------------------
// Usage: the table holds up to CAPACITY entries, each an index with saturating
// packet and byte counters, empty after reset. Requests are taken one at a
// time: a request walks the chain of slot cells, one cell per cycle, so a
// lookup, query, prune or threshold count occupies the block until its token
// leaves the last cell and its result is in the output register. A new index
// that misses needs a second walk to place the entry in the lowest free slot;
// the length of the cell chain sets how long each walk lasts. The response
// sits in an output register, so a new request is taken while the last response
// still waits. Threshold registers are written through the register channel,
// which is always ready; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module sparse_flow_counter_table import sfct_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfct_req_if.sink       req_i,
  sfct_rsp_if.source     rsp_o,
  sfct_cfg_if.sink       cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_FILL = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  word_t  pkt_thr_q, byte_thr_q;

  // launch register feeding the head of the chain
  logic   launch_act_q, launch_act_d;
  tok_t   launch_q, launch_d;

  // result waiting for the output register
  logic   pend_found_q, pend_found_d;
  word_t  pend_ptot_q, pend_ptot_d;
  word_t  pend_btot_q, pend_btot_d;
  logic   pend_drop_q, pend_drop_d;
  cnt_t   pend_hp_q, pend_hp_d;
  cnt_t   pend_hb_q, pend_hb_d;

  // output register
  logic     out_valid_q, out_valid_d;
  logic     out_load;
  logic     out_found_q;
  word_t    out_ptot_q, out_btot_q;
  logic     out_drop_q;
  out_cnt_t out_count_q, out_hp_q, out_hb_q;

  tok_t   chain [CAPACITY+1];
  tok_t   tok_end;
  logic   req_fire;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign tok_end     = chain[CAPACITY];

  always_comb begin
    chain[0]        = launch_q;
    chain[0].active = launch_act_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sfct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pkt_thr_i  (pkt_thr_q),
      .byte_thr_i (byte_thr_q),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    launch_act_d = 1'b0;
    launch_d     = launch_q;
    pend_found_d = pend_found_q;
    pend_ptot_d  = pend_ptot_q;
    pend_btot_d  = pend_btot_q;
    pend_drop_d  = pend_drop_q;
    pend_hp_d    = pend_hp_q;
    pend_hb_d    = pend_hb_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !rsp_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          // launch a fresh lookup token
          launch_act_d  = 1'b1;
          launch_d      = '0;
          launch_d.mode = mode_e'(req_i.mode);
          launch_d.key  = req_i.key_index;
          launch_d.pinc = req_i.packet_increment;
          launch_d.binc = req_i.byte_increment;
          state_d       = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_end.active) begin
          pend_found_d = 1'b0;
          pend_ptot_d  = '0;
          pend_btot_d  = '0;
          pend_drop_d  = 1'b0;
          pend_hp_d    = '0;
          pend_hb_d    = '0;
          state_d      = ST_DONE;
          case (tok_end.mode)
            MODE_ACCUM: begin
              if (tok_end.hit) begin
                pend_found_d = 1'b1;
                pend_ptot_d  = tok_end.ptot;
                pend_btot_d  = tok_end.btot;
              end else if (tok_end.any_free) begin
                // miss with room: send the insert pass down the chain
                pend_ptot_d     = tok_end.pinc;
                pend_btot_d     = tok_end.binc;
                launch_act_d    = 1'b1;
                launch_d        = tok_end;
                launch_d.fill   = 1'b1;
                launch_d.placed = 1'b0;
                state_d         = ST_FILL;
              end else begin
                pend_drop_d = 1'b1;
              end
            end
            MODE_QUERY: begin
              pend_found_d = tok_end.hit;
              pend_ptot_d  = tok_end.hit ? tok_end.ptot : '0;
              pend_btot_d  = tok_end.hit ? tok_end.btot : '0;
            end
            MODE_PRUNE: begin
              count_d = count_q - tok_end.removed;
            end
            MODE_HEAVY: begin
              pend_hp_d = tok_end.heavy_p;
              pend_hb_d = tok_end.heavy_b;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (tok_end.active) begin
          count_d = count_q + cnt_t'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      launch_act_q <= 1'b0;
      out_valid_q  <= 1'b0;
      pkt_thr_q    <= '0;
      byte_thr_q   <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      launch_act_q <= launch_act_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_PKT_THR:  pkt_thr_q  <= cfg_i.data;
          CFG_BYTE_THR: byte_thr_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    launch_q     <= launch_d;
    pend_found_q <= pend_found_d;
    pend_ptot_q  <= pend_ptot_d;
    pend_btot_q  <= pend_btot_d;
    pend_drop_q  <= pend_drop_d;
    pend_hp_q    <= pend_hp_d;
    pend_hb_q    <= pend_hb_d;
    if (out_load) begin
      out_found_q <= pend_found_q;
      out_ptot_q  <= pend_ptot_q;
      out_btot_q  <= pend_btot_q;
      out_drop_q  <= pend_drop_q;
      out_count_q <= OUT_CNT_W'(count_q);
      out_hp_q    <= OUT_CNT_W'(pend_hp_q);
      out_hb_q    <= OUT_CNT_W'(pend_hb_q);
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.found            = out_found_q;
  assign rsp_o.packet_total     = out_ptot_q;
  assign rsp_o.byte_total       = out_btot_q;
  assign rsp_o.dropped          = out_drop_q;
  assign rsp_o.entry_count      = out_count_q;
  assign rsp_o.heavy_by_packets = out_hp_q;
  assign rsp_o.heavy_by_bytes   = out_hb_q;

endmodule
`default_nettype wire

FILE: tb/sv/sfct_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfct_table_checker: result predictor and comparator for the counter table
// Keeps its own copy of the slot table and thresholds, predicts the response
// of every accepted request and compares it with the responses that arrive.
// ----------------------------------------------------------------------------
module sfct_table_checker import sfct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfct_req_if         req_i,
  sfct_rsp_if         rsp_i,
  sfct_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic     found;
    word_t    packet_total;
    word_t    byte_total;
    logic     dropped;
    out_cnt_t entry_count;
    out_cnt_t heavy_by_packets;
    out_cnt_t heavy_by_bytes;
  } table_result_t;

  // Mirror of the slot row and the threshold registers.
  logic        mirror_valid   [CAPACITY];
  word_t       mirror_key     [CAPACITY];
  word_t       mirror_packets [CAPACITY];
  word_t       mirror_bytes   [CAPACITY];
  int unsigned live_entries;
  word_t       packet_thr;
  word_t       byte_thr;

  table_result_t pending_results [$];

  function automatic word_t add_saturating(input word_t a, input word_t b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  // Apply one request to the mirror and return the response it must produce.
  function automatic table_result_t predict_counter_result(input mode_e mode,
                                                           input word_t key,
                                                           input word_t pinc,
                                                           input word_t binc);
    table_result_t res;
    int            hit_slot;
    int            free_slot;
    int unsigned   heavy_p;
    int unsigned   heavy_b;
    res       = '0;
    hit_slot  = -1;
    free_slot = -1;
    heavy_p   = 0;
    heavy_b   = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mirror_valid[i]) begin
        if (hit_slot < 0 && mirror_key[i] == key) hit_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    case (mode)
      MODE_ACCUM: begin
        if (hit_slot >= 0) begin
          mirror_packets[hit_slot] = add_saturating(mirror_packets[hit_slot], pinc);
          mirror_bytes[hit_slot]   = add_saturating(mirror_bytes[hit_slot], binc);
          res.found        = 1'b1;
          res.packet_total = mirror_packets[hit_slot];
          res.byte_total   = mirror_bytes[hit_slot];
        end else if (free_slot >= 0) begin
          mirror_valid[free_slot]   = 1'b1;
          mirror_key[free_slot]     = key;
          mirror_packets[free_slot] = pinc;
          mirror_bytes[free_slot]   = binc;
          live_entries++;
          res.packet_total = pinc;
          res.byte_total   = binc;
        end else begin
          res.dropped = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (hit_slot >= 0) begin
          res.found        = 1'b1;
          res.packet_total = mirror_packets[hit_slot];
          res.byte_total   = mirror_bytes[hit_slot];
        end
      end
      MODE_PRUNE: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (mirror_valid[i] && mirror_key[i] >= key) begin
            mirror_valid[i]   = 1'b0;
            mirror_key[i]     = '0;
            mirror_packets[i] = '0;
            mirror_bytes[i]   = '0;
            live_entries--;
          end
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (mirror_valid[i]) begin
            if (mirror_packets[i] >= packet_thr) heavy_p++;
            if (mirror_bytes[i] >= byte_thr) heavy_b++;
          end
        end
      end
    endcase
    res.entry_count      = out_cnt_t'(live_entries);
    res.heavy_by_packets = out_cnt_t'(heavy_p);
    res.heavy_by_bytes   = out_cnt_t'(heavy_b);
    return res;
  endfunction

  function automatic int unsigned field_mismatch(input string name, input logic [31:0] want,
                                                 input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    table_result_t want;
    int unsigned   errors;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        mirror_valid[i]   = 1'b0;
        mirror_key[i]     = '0;
        mirror_packets[i] = '0;
        mirror_bytes[i]   = '0;
      end
      live_entries = 0;
      packet_thr   = '0;
      byte_thr     = '0;
      pending_results.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      errors = 0;
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          $error("response arrived with no request waiting");
          errors++;
        end else begin
          want = pending_results.pop_front();
          errors += field_mismatch("found", want.found, rsp_i.found);
          errors += field_mismatch("packet_total", want.packet_total, rsp_i.packet_total);
          errors += field_mismatch("byte_total", want.byte_total, rsp_i.byte_total);
          errors += field_mismatch("dropped", want.dropped, rsp_i.dropped);
          errors += field_mismatch("entry_count", want.entry_count, rsp_i.entry_count);
          errors += field_mismatch("heavy_by_packets", want.heavy_by_packets,
                                   rsp_i.heavy_by_packets);
          errors += field_mismatch("heavy_by_bytes", want.heavy_by_bytes,
                                   rsp_i.heavy_by_bytes);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_PKT_THR:  packet_thr = cfg_i.data;
          CFG_BYTE_THR: byte_thr   = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(predict_counter_result(mode_e'(req_i.mode), req_i.key_index,
                                                         req_i.packet_increment,
                                                         req_i.byte_increment));
      end
      fail_count_o  <= fail_count_o + errors;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

FILE: tb/sv/sparse_flow_counter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_flow_counter_table_tb: stimulus and verdict for the counter table
// Runs directed corner requests, then phases of random accumulate, query,
// prune and heavy-count requests under several threshold settings, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module sparse_flow_counter_table_tb;
  import sfct_pkg::*;

  localparam int unsigned POOL_SIZE   = 128;
  localparam int unsigned NARROW_SPAN = 24;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 100;
  // Two walks of the cell row per request at worst, plus gaps and stalls.
  localparam int unsigned TAIL_CYCLES = 2 * CAPACITY + 8;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm   = 1'b0;   // no idling on either side while set
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned outstanding;
  word_t       key_pool [POOL_SIZE];

  sfct_req_if req_bus ();
  sfct_rsp_if rsp_bus ();
  sfct_cfg_if cfg_bus ();

  sparse_flow_counter_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  sfct_table_checker table_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_bus),
    .rsp_i         (rsp_bus),
    .cfg_i         (cfg_bus),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the table stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Response side: hold ready low for a random stall before each response,
  // then keep it high until one is taken. Never lower and raise in one step.
  initial begin : response_sink
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_bus.valid && rsp_bus.ready));
    end
  end

  // Present one request after a random gap and hold it until accepted.
  // Valid stays high on return so back-to-back requests need no toggle.
  task automatic send_request(input mode_e mode, input word_t key, input word_t pinc,
                              input word_t binc);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid            <= 1'b1;
    req_bus.mode             <= mode;
    req_bus.key_index        <= key;
    req_bus.packet_increment <= pinc;
    req_bus.byte_increment   <= binc;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Drop valid and wait until every predicted response has been taken.
  // The first edge lets the checker count a request accepted just now.
  task automatic drain_table();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Write both thresholds back to back; only call while the table is idle.
  task automatic write_thresholds(input word_t pkt_thr, input word_t byte_thr);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_PKT_THR;
    cfg_bus.data  <= pkt_thr;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= CFG_BYTE_THR;
    cfg_bus.data  <= byte_thr;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mix small counts, full-range values and values close to saturation.
  function automatic word_t rand_increment();
    case ($urandom_range(0, 3))
      0:       return word_t'($urandom_range(0, 15));
      1:       return word_t'($urandom);
      2:       return ~word_t'($urandom_range(0, 15));
      default: return word_t'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic word_t rand_threshold();
    case ($urandom_range(0, 2))
      0:       return word_t'($urandom_range(0, 2000));
      1:       return word_t'($urandom);
      default: return ~word_t'($urandom_range(0, 2000));
    endcase
  endfunction

  // One random request. A narrow key span drives hits and saturation, a wide
  // one fills the table until inserts are dropped.
  task automatic send_random_request(input int unsigned key_span, input int unsigned prune_pct);
    int unsigned pick;
    word_t       key;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, key_span - 1)];
    if (pick < prune_pct) begin
      if ($urandom_range(0, 3) == 0) key = word_t'($urandom);
      send_request(MODE_PRUNE, key, word_t'($urandom), word_t'($urandom));
    end else if (pick < prune_pct + 6) begin
      send_request(MODE_HEAVY, word_t'($urandom), word_t'($urandom), word_t'($urandom));
    end else if (pick < prune_pct + 18) begin
      if ($urandom_range(0, 4) == 0) key = word_t'($urandom);
      send_request(MODE_QUERY, key, word_t'($urandom), word_t'($urandom));
    end else begin
      send_request(MODE_ACCUM, key, rand_increment(), rand_increment());
    end
  endtask

  // Corner requests: empty table, zero and all-ones keys and counts,
  // saturation on both counters, hit and miss queries, prunes at the
  // extremes and reuse of a slot freed by a prune.
  task automatic run_directed();
    send_request(MODE_HEAVY, '0, '0, '0);
    send_request(MODE_QUERY, '0, '1, '1);
    send_request(MODE_ACCUM, '0, '0, '0);
    send_request(MODE_ACCUM, '1, '1, '1);
    send_request(MODE_ACCUM, '1, 32'd1, 32'd1);
    send_request(MODE_ACCUM, '0, '1, 32'd5);
    send_request(MODE_ACCUM, '0, 32'd7, '1);
    send_request(MODE_QUERY, '1, '0, '0);
    send_request(MODE_QUERY, '0, '0, '0);
    send_request(MODE_HEAVY, '1, '1, '1);
    send_request(MODE_PRUNE, 32'h8000_0000, '0, '0);
    send_request(MODE_QUERY, '1, '0, '0);
    send_request(MODE_ACCUM, 32'd5, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_ACCUM, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(MODE_PRUNE, '1, '0, '0);
    send_request(MODE_HEAVY, '0, '0, '0);
    send_request(MODE_PRUNE, '0, '1, '1);
    send_request(MODE_HEAVY, '0, '0, '0);
    send_request(MODE_QUERY, 32'd5, '0, '0);
  endtask

  initial begin : stimulus
    int unsigned key_span;
    int unsigned prune_pct;
    // Drive every input to a known value before the first edge.
    req_bus.valid            = 1'b0;
    req_bus.mode             = MODE_ACCUM;
    req_bus.key_index        = '0;
    req_bus.packet_increment = '0;
    req_bus.byte_increment   = '0;
    rsp_bus.ready            = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = CFG_PKT_THR;
    cfg_bus.data             = '0;

    // Seed the key pool with the extremes, then random indexes.
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'd1;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h8000_0000;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = word_t'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // Hold off until the table is idle before touching the thresholds.
      drain_table();
      case (phase)
        0:       write_thresholds('0, '0);
        1:       write_thresholds('1, '1);
        2:       write_thresholds(rand_threshold(), rand_threshold());
        3:       write_thresholds(word_t'($urandom), word_t'($urandom));
        default: write_thresholds(32'd1, ~word_t'(32'd1));
      endcase
      calm      = (phase == 1);
      key_span  = (phase == 1 || phase == 4) ? NARROW_SPAN : POOL_SIZE;
      prune_pct = (phase == 3) ? 0 : (phase == 4 ? 8 : 3);
      if (phase == 0) run_directed();
      repeat (PHASE_ITEMS) send_random_request(key_span, prune_pct);
    end

    // Let the last responses come back, then allow a short tail.
    drain_table();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sfct_pkg.sv
hdl/sfct_if.sv
hdl/sfct_cell.sv
hdl/sparse_flow_counter_table.sv
tb/sv/sfct_table_checker.sv
tb/sv/sparse_flow_counter_table_tb.sv
